FILE: hw/rtl/queue_reverse_prefix_interleave_assert.svh
// Assertion macros for the queue block; they expect clk and rst_n in scope.
`ifndef QUEUE_REVERSE_PREFIX_INTERLEAVE_ASSERT_SVH
`define QUEUE_REVERSE_PREFIX_INTERLEAVE_ASSERT_SVH

`ifndef SYNTH
`define QRPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrpi assertion failed");
`define QRPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrpi assertion failed");
`else
`define QRPI_ASSERT_IMP(lbl, ante, cons)
`define QRPI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/qrpi_pkg.sv
`default_nettype none
package qrpi_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 3;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam kind_t KIND_ENQ = 2'd0;
  localparam kind_t KIND_DEQ = 2'd1;
  localparam kind_t KIND_REV = 2'd2;
  localparam kind_t KIND_ILV = 2'd3;

  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_FULL  = 3'd1;
  localparam status_t ST_EMPTY = 3'd2;
  localparam status_t ST_BADK  = 3'd3;
  localparam status_t ST_ODD   = 3'd4;

endpackage
`default_nettype wire

FILE: hw/rtl/queue_reverse_prefix_interleave.sv
`default_nettype none
// Bounded circular FIFO of signed words driven by one command per beat.
// Command channel: a beat (in_kind, in_data_in, in_prefix_len) is taken on a
// rising edge with start high and busy low. busy stays high while a command
// is being worked on.
// Result channel: one result beat per command, shown for a single cycle with
// out_strobe high; out_data_out, out_status and out_occupancy are valid then.
// The receiver cannot stall the block, so results must be captured at once.
// Path from the accepting edge to the result beat:
//   enqueue and any rejected command: result registered straight from S_IDLE
//   dequeue: S_DEQ (registered read of the entry store)
//   reverse of k entries, k >= 2: S_COPY, S_BACK, S_FIN
//   interleave of c entries, c >= 2: S_COPY, S_BACK, S_FIN
// Reverse and interleave copy the entries one per cycle into a scratch store
// in their new order and then one per cycle back; a single slot adder forms
// every entry-store address. A new command may follow the result beat's cycle.
// Synchronous active-low reset empties the queue; the entry store itself is
// not cleared and no stale entry is ever read.
module queue_reverse_prefix_interleave (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [qrpi_pkg::KIND_W-1:0]       in_kind,
  input  wire logic signed [31:0]                in_data_in,
  input  wire logic [4:0]                        in_prefix_len,
  output logic                                   out_strobe,
  output logic signed [31:0]                     out_data_out,
  output logic [qrpi_pkg::STAT_W-1:0]            out_status,
  output logic [4:0]                             out_occupancy
);
  import qrpi_pkg::*;

  `include "queue_reverse_prefix_interleave_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEQ  = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_BACK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam cnt_t DEPTH_C = CNT_W'(DEPTH);
  localparam ptr_t LAST_P  = PTR_W'(DEPTH - 1);
  localparam int   KCW     = CNT_W + 5;

  logic [2:0] state_r, state_nxt;
  ptr_t       head_r, head_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       n_r, n_nxt;
  cnt_t       idx_r, idx_nxt;
  cnt_t       wr_idx_r, wr_idx_nxt;
  logic       rev_r, rev_nxt;
  logic       copy_wr_r, copy_wr_nxt;
  logic       back_wr_r, back_wr_nxt;

  logic           strobe_r, strobe_nxt;
  logic [31:0]    dout_r, dout_nxt;
  status_t        st_r, st_nxt;
  logic [4:0]     occ_r, occ_nxt;

  cnt_t                  offset;
  cnt_t                  half;
  cnt_t                  src;
  ptr_t                  slot;
  logic                  ent_we;
  logic [DATA_WIDTH-1:0] ent_wdata;
  logic [DATA_WIDTH-1:0] ent_rdata;
  logic [DATA_WIDTH-1:0] scr_rdata;

  qrpi_slot u_slot (
    .head   (head_r),
    .offset (offset),
    .slot   (slot)
  );

  qrpi_ram #(.W(DATA_WIDTH), .D(DEPTH)) u_entries (
    .clk   (clk),
    .we    (ent_we),
    .waddr (slot),
    .wdata (ent_wdata),
    .raddr (slot),
    .rdata (ent_rdata)
  );

  qrpi_ram #(.W(DATA_WIDTH), .D(DEPTH)) u_scratch (
    .clk   (clk),
    .we    (copy_wr_r),
    .waddr (wr_idx_r[PTR_W-1:0]),
    .wdata (ent_rdata),
    .raddr (idx_r[PTR_W-1:0]),
    .rdata (scr_rdata)
  );

  // source offset of the entry that lands at position idx_r
  always_comb begin
    half = n_r >> 1;
    if (rev_r) begin
      src = n_r - idx_r - CNT_W'(1);
    end else if (idx_r[0]) begin
      src = half + (idx_r >> 1);
    end else begin
      src = idx_r >> 1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    n_nxt       = n_r;
    idx_nxt     = idx_r;
    wr_idx_nxt  = wr_idx_r;
    rev_nxt     = rev_r;
    copy_wr_nxt = 1'b0;
    back_wr_nxt = 1'b0;
    strobe_nxt  = 1'b0;
    dout_nxt    = dout_r;
    st_nxt      = st_r;
    occ_nxt     = occ_r;
    offset      = '0;
    ent_we      = 1'b0;
    ent_wdata   = scr_rdata;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          strobe_nxt = 1'b1;
          dout_nxt   = '0;
          st_nxt     = ST_OK;
          occ_nxt    = 5'(count_r);
          case (in_kind)
            KIND_ENQ: begin
              offset = count_r;
              if (count_r == DEPTH_C) begin
                st_nxt = ST_FULL;
              end else begin
                ent_we    = 1'b1;
                ent_wdata = in_data_in[DATA_WIDTH-1:0];
                count_nxt = count_r + CNT_W'(1);
                occ_nxt   = 5'(count_r + CNT_W'(1));
              end
            end
            KIND_DEQ: begin
              if (count_r == '0) begin
                st_nxt   = ST_EMPTY;
                dout_nxt = '1;
              end else begin
                strobe_nxt = 1'b0;
                state_nxt  = S_DEQ;
              end
            end
            KIND_REV: begin
              if (in_prefix_len == '0 || KCW'(in_prefix_len) > KCW'(count_r)) begin
                st_nxt = ST_BADK;
              end else if (in_prefix_len != 5'd1) begin
                strobe_nxt = 1'b0;
                n_nxt      = CNT_W'(in_prefix_len);
                rev_nxt    = 1'b1;
                idx_nxt    = '0;
                state_nxt  = S_COPY;
              end
            end
            KIND_ILV: begin
              if (count_r[0]) begin
                st_nxt = ST_ODD;
              end else if (count_r != '0) begin
                strobe_nxt = 1'b0;
                n_nxt      = count_r;
                rev_nxt    = 1'b0;
                idx_nxt    = '0;
                state_nxt  = S_COPY;
              end
            end
            default: begin
              st_nxt = ST_OK;
            end
          endcase
        end
      end
      S_DEQ: begin
        strobe_nxt = 1'b1;
        dout_nxt   = 32'(signed'(ent_rdata));
        st_nxt     = ST_OK;
        occ_nxt    = 5'(count_r - CNT_W'(1));
        count_nxt  = count_r - CNT_W'(1);
        head_nxt   = (head_r == LAST_P) ? '0 : head_r + PTR_W'(1);
        state_nxt  = S_IDLE;
      end
      S_COPY: begin
        offset      = src;
        copy_wr_nxt = 1'b1;
        wr_idx_nxt  = idx_r;
        if (idx_r == n_r - CNT_W'(1)) begin
          idx_nxt   = '0;
          state_nxt = S_BACK;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_BACK: begin
        offset      = wr_idx_r;
        ent_we      = back_wr_r;
        back_wr_nxt = 1'b1;
        wr_idx_nxt  = idx_r;
        if (idx_r == n_r - CNT_W'(1)) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_FIN: begin
        offset     = wr_idx_r;
        ent_we     = back_wr_r;
        strobe_nxt = 1'b1;
        dout_nxt   = '0;
        st_nxt     = ST_OK;
        occ_nxt    = 5'(count_r);
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      copy_wr_r <= 1'b0;
      back_wr_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      copy_wr_r <= copy_wr_nxt;
      back_wr_r <= back_wr_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    idx_r    <= idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    rev_r    <= rev_nxt;
    dout_r   <= dout_nxt;
    st_r     <= st_nxt;
    occ_r    <= occ_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_strobe    = strobe_r;
  assign out_data_out  = signed'(dout_r);
  assign out_status    = st_r;
  assign out_occupancy = occ_r;

  `QRPI_ASSERT_IMP(a_count_bound, 1'b1, count_r <= DEPTH_C)
  `QRPI_ASSERT_IMP(a_no_beat_mid_move, state_r == S_COPY || state_r == S_BACK, !strobe_r)
  `QRPI_ASSERT_IMP(a_copy_idx_range, state_r == S_COPY || state_r == S_BACK, idx_r < n_r)
  `QRPI_ASSERT_NXT(a_enq_grows,
                   start && !busy && in_kind == KIND_ENQ && count_r != DEPTH_C,
                   strobe_r && count_r == $past(count_r) + CNT_W'(1))

endmodule
`default_nettype wire

FILE: hw/rtl/qrpi_ram.sv
`default_nettype none
module qrpi_ram #(
  parameter int W  = 32,
  parameter int D  = 16,
  parameter int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hw/rtl/qrpi_slot.sv
`default_nettype none
module qrpi_slot (
  input  wire qrpi_pkg::ptr_t head,
  input  wire qrpi_pkg::cnt_t offset,
  output qrpi_pkg::ptr_t      slot
);
  import qrpi_pkg::*;

  localparam logic [CNT_W:0] DEPTH_S = (CNT_W + 1)'(DEPTH);

  logic [CNT_W:0] sum;

  // head + offset modulo the queue depth
  always_comb begin
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(offset);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    slot = sum[PTR_W-1:0];
  end

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import qrpi_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RANDOM_TARGET  = 1600;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
    cnt_t               occ;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  kind_t              in_kind = KIND_ENQ;
  logic signed [31:0] in_data_in = '0;
  logic [4:0]         in_prefix_len = '0;
  logic               out_strobe;
  logic signed [31:0] out_data_out;
  logic [STAT_W-1:0]  out_status;
  logic [4:0]         out_occupancy;

  queue_reverse_prefix_interleave u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_data_in    (in_data_in),
    .in_prefix_len (in_prefix_len),
    .out_strobe    (out_strobe),
    .out_data_out  (out_data_out),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  always #2 clk = ~clk;

  // queue mirror
  logic [DATA_WIDTH-1:0] mirror_mem [DEPTH];
  int                    mirror_head = 0;
  int                    mirror_fill = 0;

  queue_result_t pending_results [$];
  int            result_errors = 0;
  int            cycle_count = 0;
  int            commands_sent = 0;
  int            kind_seen [4];
  int            status_seen [5];
  bit            no_idle = 1'b0;

  function automatic int slot_of(int i);
    return (mirror_head + i) % DEPTH;
  endfunction

  function automatic queue_result_t predict_queue_result(kind_t kind, logic [31:0] value,
                                                         logic [4:0] plen);
    queue_result_t         r;
    logic [DATA_WIDTH-1:0] swap_word;
    logic [DATA_WIDTH-1:0] woven [DEPTH];
    int                    lo;
    int                    hi;
    int                    half;
    r.value  = '0;
    r.status = ST_OK;
    case (kind)
      KIND_ENQ: begin
        if (mirror_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_mem[slot_of(mirror_fill)] = value[DATA_WIDTH-1:0];
          mirror_fill++;
        end
      end
      KIND_DEQ: begin
        if (mirror_fill == 0) begin
          r.status = ST_EMPTY;
          r.value  = -32'sd1;
        end else begin
          r.value     = signed'(mirror_mem[slot_of(0)]);
          mirror_head = (mirror_head + 1) % DEPTH;
          mirror_fill--;
        end
      end
      KIND_REV: begin
        if (plen == 0 || int'(plen) > mirror_fill) begin
          r.status = ST_BADK;
        end else begin
          lo = 0;
          hi = int'(plen) - 1;
          while (lo < hi) begin
            swap_word                = mirror_mem[slot_of(lo)];
            mirror_mem[slot_of(lo)] = mirror_mem[slot_of(hi)];
            mirror_mem[slot_of(hi)] = swap_word;
            lo++;
            hi--;
          end
        end
      end
      default: begin
        if (mirror_fill % 2 != 0) begin
          r.status = ST_ODD;
        end else begin
          half = mirror_fill / 2;
          for (int i = 0; i < half; i++) begin
            woven[2*i]   = mirror_mem[slot_of(i)];
            woven[2*i+1] = mirror_mem[slot_of(half + i)];
          end
          for (int i = 0; i < mirror_fill; i++) mirror_mem[slot_of(i)] = woven[i];
        end
      end
    endcase
    r.occ = cnt_t'(mirror_fill);
    return r;
  endfunction

  function automatic logic [31:0] edge_value(int idx);
    case (idx)
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'hffffffff;
      3:       return 32'h00000000;
      4:       return 32'h00000001;
      5:       return 32'h55555555;
      default: return 32'haaaaaaaa;
    endcase
  endfunction

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_command(kind_t kind, logic [31:0] value, logic [4:0] plen);
    queue_result_t r;
    int            gap;
    start         <= 1'b1;
    in_kind       <= kind;
    in_data_in    <= value;
    in_prefix_len <= plen;
    do @(posedge clk); while (busy);
    r = predict_queue_result(kind, value, plen);
    pending_results.push_back(r);
    commands_sent++;
    kind_seen[kind]++;
    status_seen[r.status]++;
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    issue_command(KIND_DEQ, $urandom, 5'd0);
    issue_command(KIND_REV, $urandom, 5'd0);
    issue_command(KIND_REV, $urandom, 5'd1);
    issue_command(KIND_ILV, $urandom, 5'd0);
  endtask

  task automatic test_fill_to_full();
    for (int i = 0; i < DEPTH; i++)
      issue_command(KIND_ENQ, (i < 7) ? edge_value(i) : $urandom, 5'($urandom));
    issue_command(KIND_ENQ, $urandom, 5'd0);
    issue_command(KIND_REV, $urandom, 5'd16);
    issue_command(KIND_ILV, $urandom, 5'd0);
  endtask

  task automatic test_partial_reorder();
    issue_command(KIND_DEQ, $urandom, 5'd0);
    issue_command(KIND_ILV, $urandom, 5'd0);
    issue_command(KIND_REV, $urandom, 5'd16);
    issue_command(KIND_REV, $urandom, 5'd15);
    issue_command(KIND_REV, $urandom, 5'd1);
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int          sent_here;
    int          rounds;
    int          burst;
    int          enq_weight;
    int          deq_weight;
    int          pick;
    kind_t       kind;
    logic [4:0]  plen;
    logic [31:0] value;
    sent_here = 0;
    rounds    = 0;
    while (sent_here < RANDOM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       begin enq_weight = 55; deq_weight = 15; end
        1:       begin enq_weight = 15; deq_weight = 55; end
        default: begin enq_weight = 25; deq_weight = 25; end
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      burst   = $urandom_range(20, 60);
      for (int n = 0; n < burst; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < enq_weight) kind = KIND_ENQ;
        else if (pick < enq_weight + deq_weight) kind = KIND_DEQ;
        else if (pick[0]) kind = KIND_REV;
        else kind = KIND_ILV;
        pick = $urandom_range(0, 9);
        if (mirror_fill == 0) plen = 5'($urandom_range(0, DEPTH));
        else if (pick == 0) plen = 5'd0;
        else if (pick == 1 && mirror_fill < DEPTH)
          plen = 5'($urandom_range(mirror_fill + 1, DEPTH));
        else plen = 5'($urandom_range(1, mirror_fill));
        value = ($urandom_range(0, 9) == 0) ? edge_value($urandom_range(0, 6)) : $urandom;
        issue_command(kind, value, plen);
        sent_here++;
      end
      no_idle = 1'b0;
      rounds++;
      if (rounds % 8 == 0) wait_all_results();
    end
  endtask

  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        if (result_errors < REPORT_LIMIT)
          $display("unexpected result beat: data %0d status %0d occupancy %0d",
                   out_data_out, out_status, out_occupancy);
        result_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_out !== want.value || out_status !== want.status ||
            out_occupancy !== want.occ) begin
          if (result_errors < REPORT_LIMIT)
            $display({"result mismatch: expected data %0d status %0d occupancy %0d, ",
                      "got %0d %0d %0d"},
                     want.value, want.status, want.occ, out_data_out, out_status,
                     out_occupancy);
          result_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    foreach (kind_seen[i]) kind_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_fill_to_full();
    test_partial_reorder();
    test_random_traffic();
    wait_all_results();
    $display("%0d commands: %0d enqueue, %0d dequeue, %0d reverse, %0d interleave",
             commands_sent, kind_seen[KIND_ENQ], kind_seen[KIND_DEQ], kind_seen[KIND_REV],
             kind_seen[KIND_ILV]);
    $display("rejects: %0d full, %0d empty, %0d bad k, %0d odd count; %0d errors",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_BADK],
             status_seen[ST_ODD], result_errors);
    if (result_errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
